FILE: sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion failed: same-cycle check");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed: next-cycle check");

`endif

FILE: sv/bib_pkg.sv
package bib_pkg;

	localparam int MAX_ITER_DEF = 24;
	localparam int T_FRAC_DEF   = 26;
	localparam int RATIO_FRAC   = 30;
	localparam int DIV_STEPS    = 30;
	localparam int NUM_REGS     = 8;
	localparam int ADDR_W       = 5;

	typedef logic [31:0] word_t;
	typedef word_t [NUM_REGS-1:0] cfg_t;

	localparam cfg_t REG_RESET = {32'd65536, 32'd65536, 32'd65536, 32'd65536,
		32'd0, 32'd0, 32'd0, 32'd0};

	localparam logic [1:0] KIND_INTERP = 2'd0;
	localparam logic [1:0] KIND_CLAMP  = 2'd1;
	localparam logic [1:0] KIND_FLAT   = 2'd2;

	// Interpolation steps of one de Casteljau evaluation.
	typedef enum logic [2:0] {
		OP_M01 = 3'd0,
		OP_M12 = 3'd1,
		OP_M23 = 3'd2,
		OP_A   = 3'd3,
		OP_B   = 3'd4,
		OP_S   = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SUB,
		S_MUL,
		S_ADD,
		S_DECIDE,
		S_FLAT,
		S_DIVSET,
		S_DIV,
		S_FSUB,
		S_FMUL,
		S_FADD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic check;
		logic sub;
		logic mul;
		logic add;
		logic fin;
		logic decide;
		logic flat;
		logic div_init;
		logic div_step;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic clamp;
		logic flat;
		logic ge;
	} sts_t;

endpackage

FILE: sv/bib_cfg.sv
module bib_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bib_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output bib_pkg::cfg_t                 cfg
);

	bib_pkg::cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= bib_pkg::REG_RESET;
		end else if (psel && penable && pwrite) begin
			regs_q[paddr[bib_pkg::ADDR_W-1:2]] <= pwdata;
		end
	end

	assign prdata = regs_q[paddr[bib_pkg::ADDR_W-1:2]];
	assign pready = 1'b1;
	assign cfg    = regs_q;

endmodule

FILE: sv/bib_ctrl.sv
module bib_ctrl #(
	parameter int MAX_ITER = bib_pkg::MAX_ITER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [4:0]    iterations,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          in_accept,
	output bib_pkg::cmd_t cmd,
	input  bib_pkg::sts_t sts
);

	bib_pkg::state_t state_q, state_d;
	bib_pkg::op_t    op_q, op_d;
	logic [4:0]      it_q, it_d;
	logic [4:0]      div_q, div_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bib_pkg::S_IDLE;
			op_q        <= bib_pkg::OP_M01;
			it_q        <= '0;
			div_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			it_q    <= it_d;
			div_q   <= div_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != bib_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		it_d    = it_q;
		div_d   = div_q;
		cmd     = '0;
		cmd.op  = op_q;
		case (state_q)
			bib_pkg::S_IDLE: begin
				if (in_valid) begin
					it_d    = (iterations > 5'(MAX_ITER)) ? 5'(MAX_ITER) : iterations;
					state_d = bib_pkg::S_CHECK;
				end
			end
			bib_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				op_d      = bib_pkg::OP_M01;
				if (sts.clamp) begin
					state_d = bib_pkg::S_DONE;
				end else if (it_q == 5'd0) begin
					state_d = bib_pkg::S_FLAT;
				end else begin
					state_d = bib_pkg::S_SUB;
				end
			end
			bib_pkg::S_SUB: begin
				cmd.sub = 1'b1;
				state_d = bib_pkg::S_MUL;
			end
			bib_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = bib_pkg::S_ADD;
			end
			bib_pkg::S_ADD: begin
				cmd.add = 1'b1;
				if (op_q == bib_pkg::OP_S) begin
					state_d = bib_pkg::S_DECIDE;
				end else begin
					op_d    = bib_pkg::op_t'(op_q + 3'd1);
					state_d = bib_pkg::S_SUB;
				end
			end
			bib_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				it_d       = it_q - 5'd1;
				op_d       = bib_pkg::OP_M01;
				state_d    = (it_q == 5'd1) ? bib_pkg::S_FLAT : bib_pkg::S_SUB;
			end
			bib_pkg::S_FLAT: begin
				cmd.flat = 1'b1;
				state_d  = sts.flat ? bib_pkg::S_DONE : bib_pkg::S_DIVSET;
			end
			bib_pkg::S_DIVSET: begin
				cmd.div_init = 1'b1;
				div_d        = '0;
				state_d      = sts.ge ? bib_pkg::S_FSUB : bib_pkg::S_DIV;
			end
			bib_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				div_d        = div_q + 5'd1;
				if (div_q == 5'(bib_pkg::DIV_STEPS - 1)) begin
					state_d = bib_pkg::S_FSUB;
				end
			end
			bib_pkg::S_FSUB: begin
				cmd.sub = 1'b1;
				cmd.fin = 1'b1;
				state_d = bib_pkg::S_FMUL;
			end
			bib_pkg::S_FMUL: begin
				cmd.mul = 1'b1;
				cmd.fin = 1'b1;
				state_d = bib_pkg::S_FADD;
			end
			bib_pkg::S_FADD: begin
				cmd.add = 1'b1;
				cmd.fin = 1'b1;
				state_d = bib_pkg::S_DONE;
			end
			bib_pkg::S_DONE: begin
				// Hand the result over once the output register is free.
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = bib_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bib_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/bib_dp.sv
module bib_dp #(
	parameter int T_FRAC = bib_pkg::T_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bib_pkg::cfg_t        cfg,
	input  logic                 in_accept,
	input  logic                 func,
	input  logic signed [31:0]   query,
	input  bib_pkg::cmd_t        cmd,
	output bib_pkg::sts_t        sts,
	output logic signed [31:0]   answer,
	output logic [1:0]           result_kind
);

	localparam int RF = bib_pkg::RATIO_FRAC;

	logic signed [31:0] cu_q [4];
	logic signed [31:0] cv_q [4];
	logic signed [31:0] mu_q [3];
	logic signed [31:0] mv_q [3];
	logic signed [31:0] su_q, sv_q, q_q;
	logic signed [31:0] lu_q, lv_q, ru_q, rv_q;
	logic signed [31:0] ans_q;
	logic [1:0]         kind_q;
	logic               rising_q;
	logic [T_FRAC-1:0]  guess_q, step_q;
	logic signed [31:0] au_q, av_q;
	logic signed [32:0] du_q, dv_q;
	logic [31:0]        t_q;
	logic signed [65:0] pu_q, pv_q;
	logic [32:0]        am_q, bm_q, rem_q;
	logic [RF:0]        r_q;

	logic               rising, lt;
	logic               clamp;
	logic signed [31:0] clamp_ans;
	logic signed [31:0] oau, oav, obu, obv;
	logic signed [65:0] shu, shv;
	logic signed [31:0] resu, resv;
	logic signed [32:0] dq, dr;
	logic [32:0]        am, bm;
	logic [33:0]        rem2;

	assign rising = cv_q[0] < cv_q[3];

	always_comb begin
		clamp     = 1'b1;
		clamp_ans = cu_q[0];
		if (rising && q_q < cv_q[0]) begin
			clamp_ans = cu_q[0];
		end else if (rising && q_q > cv_q[3]) begin
			clamp_ans = cu_q[3];
		end else if (!rising && q_q < cv_q[3]) begin
			clamp_ans = cu_q[3];
		end else if (!rising && q_q > cv_q[0]) begin
			clamp_ans = cu_q[0];
		end else begin
			clamp = 1'b0;
		end
	end

	always_comb begin
		oau = cu_q[0]; oav = cv_q[0]; obu = cu_q[1]; obv = cv_q[1];
		case (cmd.op)
			bib_pkg::OP_M01: begin
				oau = cu_q[0]; oav = cv_q[0]; obu = cu_q[1]; obv = cv_q[1];
			end
			bib_pkg::OP_M12: begin
				oau = cu_q[1]; oav = cv_q[1]; obu = cu_q[2]; obv = cv_q[2];
			end
			bib_pkg::OP_M23: begin
				oau = cu_q[2]; oav = cv_q[2]; obu = cu_q[3]; obv = cv_q[3];
			end
			bib_pkg::OP_A: begin
				oau = mu_q[0]; oav = mv_q[0]; obu = mu_q[1]; obv = mv_q[1];
			end
			bib_pkg::OP_B: begin
				oau = mu_q[1]; oav = mv_q[1]; obu = mu_q[2]; obv = mv_q[2];
			end
			bib_pkg::OP_S: begin
				oau = mu_q[0]; oav = mv_q[0]; obu = mu_q[1]; obv = mv_q[1];
			end
			default: begin
				oau = cu_q[0]; oav = cv_q[0]; obu = cu_q[1]; obv = cv_q[1];
			end
		endcase
		if (cmd.fin) begin
			oau = lu_q;
			obu = ru_q;
		end
	end

	// The shifted product is floor-divided; the true sum always fits in 32 bits.
	assign shu  = cmd.fin ? (pu_q >>> RF) : (pu_q >>> T_FRAC);
	assign shv  = pv_q >>> T_FRAC;
	assign resu = au_q + shu[31:0];
	assign resv = av_q + shv[31:0];
	assign lt   = sv_q < q_q;

	assign dq   = {q_q[31], q_q} - {lv_q[31], lv_q};
	assign dr   = {rv_q[31], rv_q} - {lv_q[31], lv_q};
	assign am   = dq[32] ? 33'(-dq) : 33'(dq);
	assign bm   = dr[32] ? 33'(-dr) : 33'(dr);
	assign rem2 = {rem_q, 1'b0};

	assign sts.clamp = clamp;
	assign sts.flat  = (lv_q == rv_q);
	assign sts.ge    = (am_q >= bm_q);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			for (int i = 0; i < 4; i++) begin
				cu_q[i] <= func ? cfg[2*i+1] : cfg[2*i];
				cv_q[i] <= func ? cfg[2*i] : cfg[2*i+1];
			end
			q_q     <= query;
			guess_q <= T_FRAC'(1) << (T_FRAC - 1);
			step_q  <= T_FRAC'(1) << (T_FRAC - 2);
		end
		if (cmd.check) begin
			rising_q <= rising;
			lu_q     <= cu_q[0];
			lv_q     <= cv_q[0];
			ru_q     <= cu_q[3];
			rv_q     <= cv_q[3];
			if (clamp) begin
				ans_q  <= clamp_ans;
				kind_q <= bib_pkg::KIND_CLAMP;
			end
		end
		if (cmd.sub) begin
			au_q <= oau;
			av_q <= oav;
			du_q <= {obu[31], obu} - {oau[31], oau};
			dv_q <= {obv[31], obv} - {oav[31], oav};
			t_q  <= cmd.fin ? 32'(r_q) : 32'(guess_q);
		end
		if (cmd.mul) begin
			pu_q <= du_q * $signed({1'b0, t_q});
			pv_q <= dv_q * $signed({1'b0, t_q});
		end
		if (cmd.add) begin
			if (cmd.fin) begin
				ans_q  <= resu;
				kind_q <= bib_pkg::KIND_INTERP;
			end else begin
				case (cmd.op)
					bib_pkg::OP_M01, bib_pkg::OP_A: begin
						mu_q[0] <= resu;
						mv_q[0] <= resv;
					end
					bib_pkg::OP_M12, bib_pkg::OP_B: begin
						mu_q[1] <= resu;
						mv_q[1] <= resv;
					end
					bib_pkg::OP_M23: begin
						mu_q[2] <= resu;
						mv_q[2] <= resv;
					end
					default: begin
						su_q <= resu;
						sv_q <= resv;
					end
				endcase
			end
		end
		if (cmd.decide) begin
			if (lt == rising_q) begin
				guess_q <= guess_q + step_q;
				lu_q    <= su_q;
				lv_q    <= sv_q;
			end else begin
				guess_q <= guess_q - step_q;
				ru_q    <= su_q;
				rv_q    <= sv_q;
			end
			step_q <= step_q >> 1;
		end
		if (cmd.flat) begin
			am_q <= am;
			bm_q <= bm;
			if (lv_q == rv_q) begin
				ans_q  <= lu_q;
				kind_q <= bib_pkg::KIND_FLAT;
			end
		end
		if (cmd.div_init) begin
			rem_q <= am_q;
			r_q   <= (am_q >= bm_q) ? ((RF+1)'(1) << RF) : '0;
		end
		if (cmd.div_step) begin
			if (rem2 >= {1'b0, bm_q}) begin
				rem_q <= 33'(rem2 - {1'b0, bm_q});
				r_q   <= {r_q[RF-1:0], 1'b1};
			end else begin
				rem_q <= rem2[32:0];
				r_q   <= {r_q[RF-1:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer      <= '0;
			result_kind <= bib_pkg::KIND_INTERP;
		end else if (cmd.emit) begin
			answer      <= ans_q;
			result_kind <= kind_q;
		end
	end

endmodule

FILE: sv/bezier_inverse_bisection.sv
// A clamped query goes straight from the check to the result. Otherwise N bisection steps
// run, then a flat interval gives the result at once, a saturating ratio goes straight to
// a final lerp and any other interval first runs the restoring divider for the ratio; all
// lerps share one interpolation unit (subtract, multiply, add), with 6 lerps per step.
// Throughput: one item at a time; the next can be accepted in the cycle the result appears.
// Reset clears the controller and the output and loads the control point reset values.
module bezier_inverse_bisection #(
	parameter int MAX_ITER = bib_pkg::MAX_ITER_DEF,
	parameter int T_FRAC   = bib_pkg::T_FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic signed [31:0]         query,
	input  logic [4:0]                 iterations,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [31:0]         answer,
	output logic [1:0]                 result_kind,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bib_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	bib_pkg::cfg_t cfg;
	bib_pkg::cmd_t cmd;
	bib_pkg::sts_t sts;
	logic          in_accept;

	bib_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bib_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.iterations (iterations),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.in_accept  (in_accept),
		.cmd        (cmd),
		.sts        (sts)
	);

	bib_dp #(.T_FRAC(T_FRAC)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_accept   (in_accept),
		.func        (func),
		.query       (query),
		.cmd         (cmd),
		.sts         (sts),
		.answer      (answer),
		.result_kind (result_kind)
	);

endmodule

FILE: sv/bib_checker.sv
`include "assert_macros.svh"

module bib_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [31:0]         answer,
	input logic [1:0]                 result_kind
);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(answer) && $stable(result_kind))
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`ASSERT_SAME(a_kind_legal, out_valid, result_kind <= bib_pkg::KIND_FLAT)

endmodule

bind bezier_inverse_bisection bib_checker u_bib_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.answer      (answer),
	.result_kind (result_kind)
);
